// File: hw/rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Shared widths, constants and beat types for the sphere pair tangent cone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spt_pkg;

	localparam int CRD_W       = 32;   // signed centre coordinate
	localparam int RAD_W       = 31;   // unsigned radius
	localparam int DL_W        = 33;   // signed per-axis centre difference
	localparam int SUM_W       = 66;   // sum of three squared differences
	localparam int LEN_W       = 33;   // floor sqrt of SUM_W
	localparam int TOL_W       = 16;
	localparam int TRIG_BITS   = 16;
	localparam int TRIG_W      = 17;
	localparam int DIV_LANES   = 6;
	localparam int DIV_NUM_W   = 64;
	localparam int DIV_Q_W     = 31;
	localparam int IN_TDATA_W  = 256;
	localparam int OUT_TDATA_W = 296;
	localparam int OUT_PAD_W   = 6;

	localparam logic [TOL_W-1:0]  TOL_RESET = 16'd1;
	localparam logic [TRIG_W-1:0] TRIG_ONE  = 17'd65536;

	typedef logic [2:0][CRD_W-1:0] vec3_t;
	typedef logic [RAD_W-1:0]      rad_t;
	typedef logic [TRIG_W-1:0]     trig_t;

	typedef struct packed {
		vec3_t ca;
		rad_t  ra;
		vec3_t cb;
		rad_t  rb;
	} item_t;

	// carried alongside the square root
	typedef struct packed {
		vec3_t      cl;
		vec3_t      cs;
		vec3_t      mag;
		logic [2:0] neg;
		rad_t       rl;
		rad_t       rs;
		rad_t       d;
		logic       cone;
		logic       eq;
	} sq_side_t;

	// carried alongside the first divider bank
	typedef struct packed {
		vec3_t      cl;
		vec3_t      cs;
		vec3_t      mag;
		logic [2:0] neg;
		logic       cone;
		logic       eq;
	} d1_side_t;

	// carried alongside the second divider bank
	typedef struct packed {
		vec3_t      cl;
		vec3_t      cs;
		logic [2:0] neg;
		logic       cone;
		logic       eq;
		rad_t       rsc;
		rad_t       rlc;
		trig_t      sin_a;
		trig_t      cos_a;
	} d2_side_t;

	typedef struct packed {
		trig_t cos_a;
		trig_t sin_a;
		logic  eq;
		logic  cone;
		rad_t  l_rad;
		vec3_t l_end;
		rad_t  s_rad;
		vec3_t s_end;
	} res_t;

endpackage

// File: hw/rtl/spt_front.sv
// ----------------------------------------------------------------------------
// spt_front
// Orders the spheres, forms differences, squares and the cone test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spt_front
	import spt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  item_t               in_item,
	input  logic [TOL_W-1:0]    tol,
	output logic                out_valid,
	output sq_side_t            out_side,
	output logic [SUM_W-1:0]    out_sum,
	output logic [SUM_W-1:0]    out_diff
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	item_t item_s1;

	vec3_t                 cl_s2, cs_s2;
	logic [2:0][DL_W-1:0]  dl_s2;
	rad_t                  rl_s2, rs_s2, d_s2;

	sq_side_t              sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;
	logic [2:0][2*CRD_W-1:0] sq_s4;
	logic [2*RAD_W-1:0]    dsq_s4, dsq_s5, dsq_s6;
	logic [SUM_W-1:0]      sum01_s5, sum_s6, sum_s7, diff_s7;
	logic [2*CRD_W-1:0]    sq2_s5;

	logic                  first_large;
	vec3_t                 cl_c, cs_c;
	logic [2:0][DL_W-1:0]  dl_c;
	sq_side_t              sd_c;
	sq_side_t              sd6_c;
	logic [DL_W-1:0]       ndl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// ties go to the second sphere as the large one
	always_comb begin
		first_large = item_s1.ra > item_s1.rb;
		for (int i = 0; i < 3; i++) begin
			cl_c[i] = first_large ? item_s1.ca[i] : item_s1.cb[i];
			cs_c[i] = first_large ? item_s1.cb[i] : item_s1.ca[i];
			dl_c[i] = {cs_c[i][CRD_W-1], cs_c[i]} - {cl_c[i][CRD_W-1], cl_c[i]};
		end
	end

	always_comb begin
		ndl = '0;
		sd_c = '0;
		sd_c.cl = cl_s2;
		sd_c.cs = cs_s2;
		sd_c.rl = rl_s2;
		sd_c.rs = rs_s2;
		sd_c.d  = d_s2;
		sd_c.eq = d_s2 <= RAD_W'(tol);
		for (int i = 0; i < 3; i++) begin
			ndl = -dl_s2[i];
			sd_c.neg[i] = dl_s2[i][DL_W-1];
			sd_c.mag[i] = dl_s2[i][DL_W-1] ? ndl[CRD_W-1:0] : dl_s2[i][CRD_W-1:0];
		end
	end

	always_comb begin
		sd6_c      = sd_s6;
		sd6_c.cone = sum_s6 > SUM_W'(dsq_s6);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= in_item;

			cl_s2    <= cl_c;
			cs_s2    <= cs_c;
			dl_s2    <= dl_c;
			rl_s2    <= first_large ? item_s1.ra : item_s1.rb;
			rs_s2    <= first_large ? item_s1.rb : item_s1.ra;
			d_s2     <= first_large ? (item_s1.ra - item_s1.rb) : (item_s1.rb - item_s1.ra);

			sd_s3    <= sd_c;

			sd_s4    <= sd_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= sd_s3.mag[i] * sd_s3.mag[i];
			end
			dsq_s4   <= sd_s3.d * sd_s3.d;

			sd_s5    <= sd_s4;
			sum01_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]);
			sq2_s5   <= sq_s4[2];
			dsq_s5   <= dsq_s4;

			sd_s6    <= sd_s5;
			sum_s6   <= sum01_s5 + SUM_W'(sq2_s5);
			dsq_s6   <= dsq_s5;

			sd_s7    <= sd6_c;
			sum_s7   <= sum_s6;
			diff_s7  <= sum_s6 - SUM_W'(dsq_s6);
		end
	end

	assign out_valid = v_s7;
	assign out_side  = sd_s7;
	assign out_sum   = sum_s7;
	assign out_diff  = diff_s7;

endmodule

// File: hw/rtl/spt_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// spt_sqrt_pipe
// Pipelined integer square root, one result bit per stage, several lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spt_sqrt_pipe #(
	parameter int LANES  = 2,
	parameter int IN_W   = 66,
	parameter int SIDE_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][IN_W-1:0]   in_rad,
	input  logic [SIDE_W-1:0]            in_side,
	output logic                         out_valid,
	output logic [LANES-1:0][IN_W/2-1:0] out_root,
	output logic [SIDE_W-1:0]            out_side
);

	localparam int R_W   = IN_W / 2;
	localparam int REM_W = R_W + 2;

	logic                        v_s    [R_W];
	logic [LANES-1:0][IN_W-1:0]  rad_s  [R_W];
	logic [LANES-1:0][REM_W-1:0] rem_s  [R_W];
	logic [LANES-1:0][R_W-1:0]   root_s [R_W];
	logic [SIDE_W-1:0]           side_s [R_W];

	for (genvar k = 0; k < R_W; k++) begin : g_stage
		logic                        pv;
		logic [LANES-1:0][IN_W-1:0]  prad, nrad;
		logic [LANES-1:0][REM_W-1:0] prem, nrem, tcur, trial;
		logic [LANES-1:0][R_W-1:0]   proot, nroot;
		logic [SIDE_W-1:0]           pside;

		if (k == 0) begin : g_first
			always_comb begin
				pv    = in_valid;
				prad  = in_rad;
				prem  = '0;
				proot = '0;
				pside = in_side;
			end
		end else begin : g_next
			always_comb begin
				pv    = v_s[k-1];
				prad  = rad_s[k-1];
				prem  = rem_s[k-1];
				proot = root_s[k-1];
				pside = side_s[k-1];
			end
		end

		// bring down the next two radicand bits, try root*4+1
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				tcur[l]  = {prem[l][REM_W-3:0], prad[l][IN_W-1 -: 2]};
				trial[l] = {proot[l], 2'b01};
				nrad[l]  = {prad[l][IN_W-3:0], 2'b00};
				if (tcur[l] >= trial[l]) begin
					nrem[l]  = tcur[l] - trial[l];
					nroot[l] = {proot[l][R_W-2:0], 1'b1};
				end else begin
					nrem[l]  = tcur[l];
					nroot[l] = {proot[l][R_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= nrad;
				rem_s[k]  <= nrem;
				root_s[k] <= nroot;
				side_s[k] <= pside;
			end
		end
	end

	assign out_valid = v_s[R_W-1];
	assign out_root  = root_s[R_W-1];
	assign out_side  = side_s[R_W-1];

endmodule

// File: hw/rtl/spt_div_pipe.sv
// ----------------------------------------------------------------------------
// spt_div_pipe
// Pipelined restoring divider bank, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spt_div_pipe #(
	parameter int LANES  = 6,
	parameter int NUM_W  = 64,
	parameter int DEN_W  = 33,
	parameter int Q_W    = 31,
	parameter int SIDE_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0]            in_den,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [LANES-1:0][Q_W-1:0]   out_quo,
	output logic [DEN_W-1:0]            out_den,
	output logic [SIDE_W-1:0]           out_side
);

	localparam int HI_W  = NUM_W - Q_W;
	localparam int REM_W = DEN_W + 1;

	logic                        v_s    [Q_W];
	logic [LANES-1:0][REM_W-1:0] rem_s  [Q_W];
	logic [LANES-1:0][Q_W-1:0]   work_s [Q_W];
	logic [DEN_W-1:0]            den_s  [Q_W];
	logic [SIDE_W-1:0]           side_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic                        pv;
		logic [LANES-1:0][REM_W-1:0] prem, nrem, tcur;
		logic [LANES-1:0][Q_W-1:0]   pwork, nwork;
		logic [DEN_W-1:0]            pden;
		logic [SIDE_W-1:0]           pside;
		logic [LANES-1:0]            ge;

		// upper numerator bits start as the remainder; quotient below Q_W bits
		if (k == 0) begin : g_first
			always_comb begin
				pv    = in_valid;
				pden  = in_den;
				pside = in_side;
				for (int l = 0; l < LANES; l++) begin
					prem[l]  = REM_W'(in_num[l][NUM_W-1 -: HI_W]);
					pwork[l] = in_num[l][Q_W-1:0];
				end
			end
		end else begin : g_next
			always_comb begin
				pv    = v_s[k-1];
				pden  = den_s[k-1];
				pside = side_s[k-1];
				prem  = rem_s[k-1];
				pwork = work_s[k-1];
			end
		end

		// numerator bits leave work at the top, quotient bits enter at the bottom
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				tcur[l]  = {prem[l][DEN_W-1:0], pwork[l][Q_W-1]};
				ge[l]    = tcur[l] >= {1'b0, pden};
				nrem[l]  = ge[l] ? (tcur[l] - {1'b0, pden}) : tcur[l];
				nwork[l] = {pwork[l][Q_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= nrem;
				work_s[k] <= nwork;
				den_s[k]  <= pden;
				side_s[k] <= pside;
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign out_quo   = work_s[Q_W-1];
	assign out_den   = den_s[Q_W-1];
	assign out_side  = side_s[Q_W-1];

endmodule

// File: hw/rtl/sphere_pair_tangent_cone_top.sv
// ----------------------------------------------------------------------------
// sphere_pair_tangent_cone_top
// Tangent cone of two spheres, fixed point, fully pipelined.
//
// s_axis carries one sphere pair per beat, m_axis one cone result per beat.
// cfg_we/cfg_wdata load the equal-radii tolerance (reset value 1); write it
// only while no beat is in flight.
// Throughput: one beat per clock while m_axis keeps up. Between s_axis and
// m_axis_tvalid lie the front end (7 stages), the 33-stage square root, two
// multiply stages, two 31-stage dividers and the end-point adder.
// A stalled m_axis fills a one-beat skid register; s_axis_tready then drops
// and the whole pipeline holds until the receiver takes a beat. Nothing is
// dropped or repeated.
// Reset clears all valid bits and sets the tolerance back to 1; the block
// accepts beats as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_pair_tangent_cone_top
	import spt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [TOL_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// first_center_x/y/z, first_radius, second_center_x/y/z, second_radius
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// small_end_x/y/z, small_end_radius, large_end_x/y/z, large_end_radius,
	// cone_exists, equal_radii, sin_alpha, cos_alpha
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int L_HL  = 0;
	localparam int L_HS  = 1;
	localparam int L_RLC = 2;
	localparam int L_RSC = 3;
	localparam int L_SIN = 4;
	localparam int L_COS = 5;

	logic [TOL_W-1:0] tol_q;
	logic             en;
	item_t            item;

	logic             fr_v;
	sq_side_t         fr_sd;
	logic [SUM_W-1:0] fr_sum, fr_diff;

	logic                        sq_v;
	logic [1:0][LEN_W-1:0]       sq_root;
	sq_side_t                    sq_sd;

	logic [2*RAD_W-1:0]          p_rl_d, p_rs_d;
	logic [RAD_W+LEN_W-1:0]      p_rl_s, p_rs_s;
	logic [DIV_LANES-1:0][DIV_NUM_W-1:0] num1_c, num1_s1, num2_c, num2_s2;
	d1_side_t                    sd1_c, sd1_s1;
	logic [LEN_W-1:0]            len_s1, len_s2;
	logic                        v_s1, v_s2, v_s3;

	logic                        d1_v;
	logic [DIV_LANES-1:0][DIV_Q_W-1:0] q1;
	logic [LEN_W-1:0]            d1_len;
	d1_side_t                    d1_sd;

	logic [CRD_W+DIV_Q_W-1:0]    poff [DIV_LANES];
	d2_side_t                    sd2_c, sd2_s2;

	logic                        d2_v;
	logic [DIV_LANES-1:0][DIV_Q_W-1:0] q2;
	d2_side_t                    d2_sd;

	res_t                        res_c, res_s3;
	logic [CRD_W+1:0]            ext, qq, acc;
	logic [CRD_W-1:0]            sat;

	logic out_valid_q, skid_valid_q, take;
	res_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	assign item.ca = s_axis_tdata[3*CRD_W-1:0];
	assign item.ra = s_axis_tdata[3*CRD_W+RAD_W-1 -: RAD_W];
	assign item.cb = s_axis_tdata[6*CRD_W+RAD_W-1 -: 3*CRD_W];
	assign item.rb = s_axis_tdata[6*CRD_W+2*RAD_W-1 -: RAD_W];

	spt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_item   (item),
		.tol       (tol_q),
		.out_valid (fr_v),
		.out_side  (fr_sd),
		.out_sum   (fr_sum),
		.out_diff  (fr_diff)
	);

	spt_sqrt_pipe #(
		.LANES  (2),
		.IN_W   (SUM_W),
		.SIDE_W ($bits(sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_v),
		.in_rad    ({fr_diff, fr_sum}),
		.in_side   (fr_sd),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_side  (sq_sd)
	);

	// lane 0 is L, lane 1 is s
	always_comb begin
		p_rl_d = sq_sd.rl * sq_sd.d;
		p_rs_d = sq_sd.rs * sq_sd.d;
		p_rl_s = sq_sd.rl * sq_root[1];
		p_rs_s = sq_sd.rs * sq_root[1];
		num1_c[L_HL]  = DIV_NUM_W'(p_rl_d);
		num1_c[L_HS]  = DIV_NUM_W'(p_rs_d);
		num1_c[L_RLC] = DIV_NUM_W'(p_rl_s);
		num1_c[L_RSC] = DIV_NUM_W'(p_rs_s);
		num1_c[L_SIN] = DIV_NUM_W'({sq_sd.d, {TRIG_BITS{1'b0}}});
		num1_c[L_COS] = DIV_NUM_W'({sq_root[1], {TRIG_BITS{1'b0}}});
		sd1_c.cl   = sq_sd.cl;
		sd1_c.cs   = sq_sd.cs;
		sd1_c.mag  = sq_sd.mag;
		sd1_c.neg  = sq_sd.neg;
		sd1_c.cone = sq_sd.cone;
		sd1_c.eq   = sq_sd.eq;
	end

	spt_div_pipe #(
		.LANES  (DIV_LANES),
		.NUM_W  (DIV_NUM_W),
		.DEN_W  (LEN_W),
		.Q_W    (DIV_Q_W),
		.SIDE_W ($bits(d1_side_t))
	) u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_num    (num1_s1),
		.in_den    (len_s1),
		.in_side   (sd1_s1),
		.out_valid (d1_v),
		.out_quo   (q1),
		.out_den   (d1_len),
		.out_side  (d1_sd)
	);

	// offsets: lanes 0..2 small side (by hs), lanes 3..5 large side (by hl)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			poff[i]     = d1_sd.mag[i] * q1[L_HS];
			poff[3 + i] = d1_sd.mag[i] * q1[L_HL];
		end
		for (int l = 0; l < DIV_LANES; l++) begin
			num2_c[l] = DIV_NUM_W'(poff[l]);
		end
		sd2_c.cl    = d1_sd.cl;
		sd2_c.cs    = d1_sd.cs;
		sd2_c.neg   = d1_sd.neg;
		sd2_c.cone  = d1_sd.cone;
		sd2_c.eq    = d1_sd.eq;
		sd2_c.rsc   = q1[L_RSC];
		sd2_c.rlc   = q1[L_RLC];
		sd2_c.sin_a = q1[L_SIN][TRIG_W-1:0];
		sd2_c.cos_a = q1[L_COS][TRIG_W-1:0];
	end

	spt_div_pipe #(
		.LANES  (DIV_LANES),
		.NUM_W  (DIV_NUM_W),
		.DEN_W  (LEN_W),
		.Q_W    (DIV_Q_W),
		.SIDE_W ($bits(d2_side_t))
	) u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_num    (num2_s2),
		.in_den    (len_s2),
		.in_side   (sd2_s2),
		.out_valid (d2_v),
		.out_quo   (q2),
		.out_den   (),
		.out_side  (d2_sd)
	);

	// end = centre +/- offset, saturated; all geometry zero without a cone
	always_comb begin
		ext = '0;
		qq  = '0;
		acc = '0;
		sat = '0;
		res_c = '0;
		res_c.cone = d2_sd.cone;
		res_c.eq   = d2_sd.eq;
		for (int l = 0; l < DIV_LANES; l++) begin
			if (l < 3) begin
				ext = {{2{d2_sd.cs[l][CRD_W-1]}}, d2_sd.cs[l]};
			end else begin
				ext = {{2{d2_sd.cl[l-3][CRD_W-1]}}, d2_sd.cl[l-3]};
			end
			qq  = (CRD_W+2)'(q2[l]);
			acc = d2_sd.neg[l % 3] ? (ext - qq) : (ext + qq);
			if (!acc[CRD_W+1] && (acc[CRD_W:CRD_W-1] != 2'b00)) begin
				sat = {1'b0, {(CRD_W-1){1'b1}}};
			end else if (acc[CRD_W+1] && (acc[CRD_W:CRD_W-1] != 2'b11)) begin
				sat = {1'b1, {(CRD_W-1){1'b0}}};
			end else begin
				sat = acc[CRD_W-1:0];
			end
			if (d2_sd.cone) begin
				if (l < 3) begin
					res_c.s_end[l] = sat;
				end else begin
					res_c.l_end[l-3] = sat;
				end
			end
		end
		if (d2_sd.cone) begin
			res_c.s_rad = d2_sd.rsc;
			res_c.l_rad = d2_sd.rlc;
			res_c.sin_a = d2_sd.sin_a;
			res_c.cos_a = d2_sd.cos_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= sq_v;
			v_s2 <= d1_v;
			v_s3 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s1 <= num1_c;
			len_s1  <= sq_root[0];
			sd1_s1  <= sd1_c;
			num2_s2 <= num2_c;
			len_s2  <= d1_len;
			sd2_s2  <= sd2_c;
			res_s3  <= res_c;
		end
	end

	// output register plus one-beat skid
	assign take = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (v_s3) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (v_s3) begin
			if (!out_valid_q || take) begin
				out_q <= res_s3;
			end else begin
				skid_q <= res_s3;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q};

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid filled without a stalled output beat");

	a_no_cone_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.cone) |->
		(out_q.s_rad == '0 && out_q.l_rad == '0 && out_q.s_end == '0 &&
		 out_q.l_end == '0 && out_q.sin_a == '0 && out_q.cos_a == '0))
		else $error("geometry not cleared on a beat without a cone");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.sin_a <= TRIG_ONE && out_q.cos_a <= TRIG_ONE))
		else $error("sin or cos above one");
`endif

endmodule

// File: verif/sphere_pair_tangent_cone_checker.sv
// ----------------------------------------------------------------------------
// sphere_pair_tangent_cone_checker
// Watches both stream ports and the tolerance write of the tangent cone block.
// Each accepted sphere pair beat is turned into a predicted cone result. Each
// result beat is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_pair_tangent_cone_checker
	import spt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [TOL_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output int                     fail_count,
	output int                     pending
);

	typedef struct {
		logic [CRD_W-1:0]  s_end [3];
		logic [RAD_W-1:0]  s_rad;
		logic [CRD_W-1:0]  l_end [3];
		logic [RAD_W-1:0]  l_rad;
		logic              cone;
		logic              eq;
		logic [TRIG_W-1:0] sin_a;
		logic [TRIG_W-1:0] cos_a;
	} cone_res_t;

	cone_res_t        cone_queue [$];
	logic [TOL_W-1:0] tolerance;

	function automatic logic [127:0] isqrt(logic [127:0] n);
		logic [127:0] res;
		logic [127:0] cand;
		res = '0;
		for (int b = 33; b >= 0; b--) begin
			cand = res | (128'd1 << b);
			if (cand * cand <= n)
				res = cand;
		end
		return res;
	endfunction

	function automatic logic [CRD_W-1:0] sat_add(longint base, logic [127:0] q, logic neg);
		longint e;
		e = neg ? base - longint'(q[62:0]) : base + longint'(q[62:0]);
		if (e > 64'sh7FFFFFFF)
			e = 64'sh7FFFFFFF;
		if (e < -64'sh80000000)
			e = -64'sh80000000;
		return e[CRD_W-1:0];
	endfunction

	function automatic cone_res_t predict_cone(logic [IN_TDATA_W-1:0] t,
	                                           logic [TOL_W-1:0] tol);
		cone_res_t    r;
		longint       ca [3];
		longint       cb [3];
		longint       cl [3];
		longint       cs [3];
		logic [127:0] mag [3];
		logic         neg [3];
		logic [127:0] ra, rb, rl, rs, d, dsq, sum, len, side, hl, hs;
		logic         first_large;
		for (int i = 0; i < 3; i++) begin
			ca[i] = longint'($signed(t[i*32 +: 32]));
			cb[i] = longint'($signed(t[127 + i*32 +: 32]));
		end
		ra = 128'(t[126:96]);
		rb = 128'(t[253:223]);
		first_large = ra > rb;
		rl = first_large ? ra : rb;
		rs = first_large ? rb : ra;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			longint dl;
			cl[i] = first_large ? ca[i] : cb[i];
			cs[i] = first_large ? cb[i] : ca[i];
			dl = cs[i] - cl[i];
			neg[i] = dl < 0;
			mag[i] = 128'(neg[i] ? -dl : dl);
			sum = sum + mag[i] * mag[i];
		end
		d = rl - rs;
		dsq = d * d;
		r.cone = sum > dsq;
		r.eq = d <= 128'(tol);
		r.s_rad = '0;
		r.l_rad = '0;
		r.sin_a = '0;
		r.cos_a = '0;
		for (int i = 0; i < 3; i++) begin
			r.s_end[i] = '0;
			r.l_end[i] = '0;
		end
		if (r.cone) begin
			len = isqrt(sum);
			side = isqrt(sum - dsq);
			hl = (rl * d) / len;
			hs = (rs * d) / len;
			r.l_rad = 31'((rl * side) / len);
			r.s_rad = 31'((rs * side) / len);
			for (int i = 0; i < 3; i++) begin
				r.s_end[i] = sat_add(cs[i], (mag[i] * hs) / len, neg[i]);
				r.l_end[i] = sat_add(cl[i], (mag[i] * hl) / len, neg[i]);
			end
			r.sin_a = 17'((d << TRIG_BITS) / len);
			r.cos_a = 17'((side << TRIG_BITS) / len);
		end
		return r;
	endfunction

	function automatic cone_res_t unpack_result(logic [OUT_TDATA_W-1:0] t);
		cone_res_t r;
		for (int i = 0; i < 3; i++) begin
			r.s_end[i] = t[i*32 +: 32];
			r.l_end[i] = t[127 + i*32 +: 32];
		end
		r.s_rad = t[126:96];
		r.l_rad = t[253:223];
		r.cone  = t[254];
		r.eq    = t[255];
		r.sin_a = t[272:256];
		r.cos_a = t[289:273];
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance <= TOL_RESET;
			cone_queue.delete();
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				cone_res_t got, want;
				got = unpack_result(m_axis_tdata);
				if (cone_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: result beat with nothing expected");
				end else begin
					want = cone_queue.pop_front();
					check_field("small_end_x", want.s_end[0], got.s_end[0]);
					check_field("small_end_y", want.s_end[1], got.s_end[1]);
					check_field("small_end_z", want.s_end[2], got.s_end[2]);
					check_field("small_end_radius", want.s_rad, got.s_rad);
					check_field("large_end_x", want.l_end[0], got.l_end[0]);
					check_field("large_end_y", want.l_end[1], got.l_end[1]);
					check_field("large_end_z", want.l_end[2], got.l_end[2]);
					check_field("large_end_radius", want.l_rad, got.l_rad);
					check_field("cone_exists", want.cone, got.cone);
					check_field("equal_radii", want.eq, got.eq);
					check_field("sin_alpha", want.sin_a, got.sin_a);
					check_field("cos_alpha", want.cos_a, got.cos_a);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				cone_queue.push_back(predict_cone(s_axis_tdata, tolerance));
			if (cfg_we)
				tolerance <= cfg_wdata;
		end
	end

	assign pending = cone_queue.size();

endmodule

// File: verif/tb_sphere_pair_tangent_cone_top.sv
// ----------------------------------------------------------------------------
// tb_sphere_pair_tangent_cone_top
// Stimulus for the sphere pair tangent cone block. A directed set of corner
// pairs comes first, then random pairs in phases with different tolerances
// and idle patterns on both sides, including one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sphere_pair_tangent_cone_top;
	import spt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 125;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [TOL_W-1:0]       cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	int                     fail_count;
	int                     pending;

	int   send_idle = 0;
	int   recv_stall = 0;
	logic hold_go = 1'b0;
	int   hold_left = 0;
	int   cycles = 0;

	sphere_pair_tangent_cone_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	sphere_pair_tangent_cone_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_go) begin
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
	                         logic [30:0] ar, logic [31:0] bx, logic [31:0] by,
	                         logic [31:0] bz, logic [30:0] br);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, br, bz, by, bx, ar, az, ay, ax};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_tolerance(logic [TOL_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2097151)) - 1048576);
			2: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(65535)
			                            : 32'h80000000 + $urandom_range(65535);
			default: return 32'($signed($urandom_range(32'h1FFFFFFF)) - 32'sh10000000);
		endcase
	endfunction

	function automatic logic [30:0] rnd_radius();
		case ($urandom_range(4))
			0: return 31'($urandom);
			1: return 31'($urandom_range(1048575));
			2: return 31'h7FFFFFFF - 31'($urandom_range(255));
			3: return 31'($urandom_range(3));
			default: return 31'($urandom_range(32'h0FFFFFFF));
		endcase
	endfunction

	task automatic send_random();
		logic [31:0] ax, ay, az, bx, by, bz;
		logic [30:0] ar, br;
		ax = rnd_coord();
		ay = rnd_coord();
		az = rnd_coord();
		ar = rnd_radius();
		case ($urandom_range(9))
			0: begin  // shared centre
				bx = ax; by = ay; bz = az;
			end
			1: begin  // nearby centre, often nested spheres
				bx = ax + $urandom_range(4095);
				by = ay - $urandom_range(4095);
				bz = az;
			end
			default: begin
				bx = rnd_coord(); by = rnd_coord(); bz = rnd_coord();
			end
		endcase
		case ($urandom_range(5))
			0: br = ar;
			1: br = ar + 31'($urandom_range(3));
			default: br = rnd_radius();
		endcase
		send_pair(ax, ay, az, ar, bx, by, bz, br);
	endtask

	initial begin
		logic [TOL_W-1:0] tol_set [4];
		int               idle_set [4];
		int               stall_set [4];
		tol_set   = '{16'd0, 16'hFFFF, 16'd0, 16'd1};
		tol_set[2] = 16'($urandom);
		idle_set  = '{0, 83, 0, 26};
		stall_set = '{0, 0, 83, 26};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_tolerance(16'd1);

		// coincident centres, all zero and all ones patterns
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
		          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
		send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
		          32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		// opposite extreme corners, largest radii both ways
		send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
		          32'h80000000, 32'h80000000, 32'h80000000, 0);
		send_pair(32'h80000000, 32'h80000000, 32'h80000000, 0,
		          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
		send_pair(32'h80000000, 32'h7FFFFFFF, 0, 31'h7FFFFFFF,
		          32'h7FFFFFFF, 32'h80000000, 0, 31'h7FFFFFFF);
		// equal radii: second sphere is the large one
		send_pair(32'h00010000, 0, 0, 31'h00008000, 32'hFFFF0000, 0, 0, 31'h00008000);
		// radius difference at and just past the tolerance
		send_pair(0, 0, 0, 31'd1000, 32'h00100000, 0, 0, 31'd1001);
		send_pair(0, 0, 0, 31'd1002, 32'h00100000, 0, 0, 31'd1000);
		// nested spheres: no cone, distance equal to radius difference, and just past it
		send_pair(0, 0, 0, 31'h00100000, 32'h00001000, 0, 0, 31'h00000100);
		send_pair(0, 0, 0, 31'd500, 32'd300, 32'd400, 0, 31'd1000);
		send_pair(0, 0, 0, 31'd500, 32'd300, 32'd400, 0, 31'd999);
		// end points pushed past the signed range
		send_pair(32'h7FFF0000, 32'h80010000, 0, 31'h7FFF0000,
		          32'h7FFFFFFF, 32'h80000000, 0, 31'h10000000);
		send_pair(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 31'h00010000,
		          32'h00000000, 32'h00000000, 32'h00000000, 31'h7FFFFFFF);
		// tiny distances, and one pair of mixed bit patterns
		send_pair(0, 0, 0, 0, 1, 0, 0, 0);
		send_pair(0, 0, 0, 1, 0, 0, 32'hFFFFFFFF, 0);
		send_pair(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 31'h55555555,
		          32'hEDCBA987, 32'h65432110, 32'hF0F0F0F0, 31'h2AAAAAAA);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_tolerance(tol_set[p]);
			send_idle  = idle_set[p];
			recv_stall = stall_set[p];
			if (p == 0) begin
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random();
			drain();
		end

		repeat (120) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
